FILE: src/bta_pkg.sv
// Shared widths, constants and command codes of the block table allocator.
package bta_pkg;

  localparam int SIZE_W   = 16;
  localparam int OFFSET_W = 13;
  localparam int PERM_W   = 10;
  localparam int PERMILLE = 1000;

  localparam int DEF_BLOCK_COUNT = 256;
  localparam int DEF_BLOCK_SIZE  = 32;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

FILE: src/bta_req_if.sv
// Request channel of the block table allocator: one allocate or free command per item.
interface bta_req_if import bta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [SIZE_W-1:0] size_bytes;
  logic [SIZE_W-1:0] free_offset;

  modport source (output valid, command, size_bytes, free_offset, input ready);
  modport sink (input valid, command, size_bytes, free_offset, output ready);
endinterface

FILE: src/bta_rsp_if.sv
// Response channel of the block table allocator: one result item per command.
interface bta_rsp_if import bta_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                ok;
  logic [OFFSET_W-1:0] offset;
  logic [PERM_W-1:0]   usage_permille;

  modport source (output valid, ok, offset, usage_permille, input ready);
  modport sink (input valid, ok, offset, usage_permille, output ready);
endinterface

FILE: src/bta_mem.sv
// Block table storage: one write port and one read port with registered read data.
module bta_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bta_div.sv
// Division by a fixed divisor through multiplication with its rounded-up reciprocal.
module bta_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR    = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  // With SHIFT = DIVIDEND_W + ceil(log2(DIVISOR)) and RECIP = ceil(2^SHIFT / DIVISOR),
  // the error of the reciprocal times any dividend stays below 2^SHIFT, so
  // (x * RECIP) >> SHIFT equals x / DIVISOR for every dividend that fits the port.
  localparam int     SHIFT = DIVIDEND_W + $clog2(DIVISOR);
  localparam int     MUL_W = SHIFT + DIVIDEND_W;
  localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) /
                             longint'(DIVISOR);

  logic                  stage;
  logic [DIVIDEND_W-1:0] dvd;
  logic [MUL_W-1:0]      prod;

  // The reciprocal is at most DIVIDEND_W + 2 bits wide; the upper operand bits are zero.
  assign prod = MUL_W'(dvd) * MUL_W'(RECIP);

  // The dividend is registered first and the quotient from its product in the cycle
  // after, when done rises.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 1'b0;
      done  <= 1'b0;
    end else begin
      stage <= start;
      done  <= stage;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
    end
    if (stage) begin
      quotient <= prod[SHIFT +: DIVIDEND_W];
    end
  end

endmodule

FILE: src/block_table_allocator.sv
// Top level of the block table allocator: command sequencer around the block table.
//
// The pool holds BLOCK_COUNT blocks of BLOCK_SIZE bytes each, tracked by a table
// with one entry per block that holds the length of the allocation covering it,
// or zero when the block is free. The table sits in a single-port-write,
// single-port-read synchronous memory; commands that use it walk it one entry
// per cycle, and one command is in flight at a time. After reset the block writes
// zeros through every table entry and holds req.ready low until that pass is over.
// An allocate examines entries downward from the top of the table up to the lowest
// block of the first fitting free run and then writes the run length back into each
// of its entries; when no run fits it examines the whole table, and a zero-size
// allocate skips the scan. A free walks upward from the freed block over as many
// entries as its stored count (clipped at the table end) and clears them; it skips
// the walk when that block is already free or the offset lies beyond the pool. Both
// divisions, the byte offset into a block index and the used count into permille,
// are by fixed pool figures and are done by a pipelined reciprocal multiplication
// that registers the dividend and then the quotient. The result is held in an
// output register, so the next command can be accepted while the previous result
// waits to be taken; a finished result that finds the register still occupied waits
// until the held result is taken.
module block_table_allocator import bta_pkg::*; #(
  parameter int BLOCK_COUNT = DEF_BLOCK_COUNT,
  parameter int BLOCK_SIZE  = DEF_BLOCK_SIZE
) (
  input logic      clk,
  input logic      rst,
  bta_req_if.sink  req,
  bta_rsp_if.source rsp
);

  // Table index, counter and entry widths.
  localparam int IW    = $clog2(BLOCK_COUNT);
  localparam int CW    = $clog2(BLOCK_COUNT + 1);
  localparam int BS_W  = $clog2(BLOCK_SIZE + 1);
  // Running byte length of a free run; the scan stops before it passes the
  // request by a whole block.
  localparam int RB_W  = $clog2((1 << SIZE_W) + BLOCK_SIZE);
  localparam int PROD_W = $clog2(BLOCK_COUNT * PERMILLE + 1);
  localparam int OFFP_W = (IW + BS_W > OFFSET_W) ? IW + BS_W : OFFSET_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_MARK  = 4'd3;
  localparam logic [3:0] S_FDIV  = 4'd4;
  localparam logic [3:0] S_FN    = 4'd5;
  localparam logic [3:0] S_FCLR  = 4'd6;
  localparam logic [3:0] S_USAGE = 4'd7;
  localparam logic [3:0] S_UWAIT = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]          state;

  // Command registers.
  logic [SIZE_W-1:0]   size;

  // Table walk: read pointer, the entry whose data returns this cycle, and run state.
  logic [CW-1:0]       rd_addr;
  logic                rd_more;
  logic                p_vld;
  logic [IW-1:0]       p_idx;
  logic [CW-1:0]       run;
  logic [RB_W-1:0]     rb;
  logic [IW-1:0]       wr_idx;
  logic [CW-1:0]       need;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       used;

  // Result being assembled.
  logic                res_ok;
  logic [OFFSET_W-1:0] res_off;
  logic [PERM_W-1:0]   res_pm;

  // Output register.
  logic                out_valid;
  logic                out_ok;
  logic [OFFSET_W-1:0] out_off;
  logic [PERM_W-1:0]   out_pm;

  // Memory and divider connections.
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [CW-1:0]       mem_wdata;
  logic                mem_re;
  logic [IW-1:0]       mem_raddr;
  logic [CW-1:0]       mem_rdata;

  logic                blk_start;
  logic                blk_done;
  logic [SIZE_W-1:0]   blk_q;
  logic                pm_start;
  logic                pm_done;
  logic [PROD_W-1:0]   pm_q;

  logic                accept;
  logic                issue;
  logic                entry_free;
  logic [CW-1:0]       run_n;
  logic [RB_W-1:0]     rb_n;
  logic                hit;
  logic [OFFP_W-1:0]   off_prod;
  logic [PROD_W-1:0]   use_prod;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // Scan step: extend the current free run by the entry that has just been read,
  // in blocks and in bytes. The run fits as soon as its byte length covers the request.
  assign entry_free = (mem_rdata == '0);
  assign run_n      = entry_free ? CW'(run + 1'b1) : '0;
  assign rb_n       = entry_free ? RB_W'(rb + RB_W'(BLOCK_SIZE)) : '0;
  assign hit        = p_vld && entry_free && (rb_n >= RB_W'(size));
  assign off_prod   = OFFP_W'(p_idx) * OFFP_W'(BLOCK_SIZE);

  // Freeing walks upward from the given block while entries remain and the
  // table has not ended.
  assign issue = (cnt != '0) && (rd_addr < CW'(BLOCK_COUNT));

  assign use_prod = PROD_W'(used) * PROD_W'(PERMILLE);

  // One divider turns the byte offset of an accepted free into a block index,
  // the other turns the used count into permille at the end of every command.
  assign blk_start = accept && (req.command == CMD_FREE);
  assign pm_start  = (state == S_USAGE);

  // Table port control. Reads and writes in the same cycle always touch
  // different entries, since freeing writes the entry behind its read pointer.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = rd_addr[IW-1:0];
      end
      S_SCAN: begin
        mem_re    = rd_more;
        mem_raddr = rd_addr[IW-1:0];
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = wr_idx;
        mem_wdata = need;
      end
      S_FDIV: begin
        mem_re    = blk_done;
        mem_raddr = blk_q[IW-1:0];
      end
      S_FCLR: begin
        mem_re    = issue;
        mem_raddr = rd_addr[IW-1:0];
        mem_we    = p_vld && !entry_free;
        mem_waddr = p_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rd_addr   <= '0;
      used      <= '0;
      out_valid <= 1'b0;
      p_vld     <= 1'b0;
      rd_more   <= 1'b0;
      cnt       <= '0;
    end else begin
      // The output register refills when a finished command finds it free or
      // being emptied, and otherwise empties when its item is taken.
      if ((state == S_OUT) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          rd_addr <= rd_addr + 1'b1;
          if (rd_addr == CW'(BLOCK_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            size    <= req.size_bytes;
            res_ok  <= 1'b0;
            res_off <= '0;
            if (req.command == CMD_FREE) begin
              state <= S_FDIV;
            end else if (req.size_bytes == '0) begin
              state <= S_USAGE;
            end else begin
              rd_addr <= CW'(BLOCK_COUNT - 1);
              rd_more <= 1'b1;
              p_vld   <= 1'b0;
              run     <= '0;
              rb      <= '0;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Reads run one entry ahead of the data under evaluation.
          p_vld <= rd_more;
          p_idx <= rd_addr[IW-1:0];
          if (rd_addr == '0) begin
            rd_more <= 1'b0;
          end else begin
            rd_addr <= rd_addr - 1'b1;
          end
          if (p_vld) begin
            run <= run_n;
            rb  <= rb_n;
            if (hit) begin
              wr_idx  <= p_idx;
              need    <= run_n;
              cnt     <= run_n;
              res_off <= off_prod[OFFSET_W-1:0];
              state   <= S_MARK;
            end else if (p_idx == '0) begin
              state <= S_USAGE;
            end
          end
        end
        S_MARK: begin
          wr_idx <= wr_idx + 1'b1;
          cnt    <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            used   <= CW'(used + need);
            res_ok <= 1'b1;
            state  <= S_USAGE;
          end
        end
        S_FDIV: begin
          if (blk_done) begin
            if (blk_q >= SIZE_W'(BLOCK_COUNT)) begin
              state <= S_USAGE;
            end else begin
              rd_addr <= blk_q[CW-1:0];
              state   <= S_FN;
            end
          end
        end
        S_FN: begin
          // The entry at the freed block gives how many entries to clear.
          res_ok <= 1'b1;
          p_vld  <= 1'b0;
          cnt    <= mem_rdata;
          if (entry_free) begin
            state <= S_USAGE;
          end else begin
            state <= S_FCLR;
          end
        end
        S_FCLR: begin
          p_vld <= issue;
          p_idx <= rd_addr[IW-1:0];
          if (issue) begin
            rd_addr <= rd_addr + 1'b1;
            cnt     <= cnt - 1'b1;
          end
          if (p_vld && !entry_free && (used != '0)) begin
            used <= used - 1'b1;
          end
          if (!issue && !p_vld) begin
            state <= S_USAGE;
          end
        end
        S_USAGE: begin
          state <= S_UWAIT;
        end
        S_UWAIT: begin
          if (pm_done) begin
            res_pm <= pm_q[PERM_W-1:0];
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_ok  <= res_ok;
            out_off <= res_off;
            out_pm  <= res_pm;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.ok             = out_ok;
  assign rsp.offset         = out_off;
  assign rsp.usage_permille = out_pm;

  bta_mem #(
    .DEPTH (BLOCK_COUNT),
    .WIDTH (CW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bta_div #(
    .DIVIDEND_W (SIZE_W),
    .DIVISOR    (BLOCK_SIZE)
  ) u_blk_div (
    .clk      (clk),
    .rst      (rst),
    .start    (blk_start),
    .dividend (req.free_offset),
    .done     (blk_done),
    .quotient (blk_q)
  );

  bta_div #(
    .DIVIDEND_W (PROD_W),
    .DIVISOR    (BLOCK_COUNT)
  ) u_pm_div (
    .clk      (clk),
    .rst      (rst),
    .start    (pm_start),
    .dividend (use_prod),
    .done     (pm_done),
    .quotient (pm_q)
  );

  // The table is never written while the block waits for a command.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("table written while idle");

  // The used count can never exceed the pool.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(BLOCK_COUNT))
    else $error("used block count beyond pool size");

  // A nonzero offset only comes with a successful allocation.
  a_offset_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.offset != '0)) |-> rsp.ok)
    else $error("offset reported for a failed command");

  // A block index only arrives while the sequencer is waiting for one.
  a_blk_div_state: assert property (@(posedge clk) disable iff (rst)
    blk_done |-> (state == S_FDIV))
    else $error("block index ready outside its waiting state");

  // A usage figure only arrives while the sequencer is waiting for one.
  a_pm_div_state: assert property (@(posedge clk) disable iff (rst)
    pm_done |-> (state == S_UWAIT))
    else $error("usage figure ready outside its waiting state");

endmodule
